FILE: sv/text_console_cursor_engine_defines.svh
// assertion macros shared by the text console cursor engine modules
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define TCCE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define TCCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tcce_pkg.sv
// types, constants and helper functions of the text console cursor engine
package tcce_pkg;

  // screen limits and tab spacing
  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 128;
  localparam int TAB_STOP = 4;

  // field widths
  localparam int COL_W    = 8;
  localparam int ROW_W    = 7;
  localparam int NCOL_W   = 9;
  localparam int NROW_W   = 8;
  localparam int CODE_W   = 8;
  localparam int PIX_W    = 32;
  localparam int ADDR_W   = 3;
  localparam int IN_DW    = 24;
  localparam int OUT_DW   = 104;

  // request kinds
  localparam logic REQ_PUT = 1'b0;
  localparam logic REQ_SET = 1'b1;

  // character codes
  localparam logic [CODE_W-1:0] CH_BS    = 8'h08;
  localparam logic [CODE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CODE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CODE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CODE_W-1:0] CH_DEL   = 8'h7F;

  // pixel formats
  localparam logic FMT_BGRA = 1'b0;
  localparam logic FMT_RGBA = 1'b1;

  // register reset values
  localparam logic              RST_ENABLE   = 1'b0;
  localparam logic [NCOL_W-1:0] RST_NUM_COLS = 9'd128;
  localparam logic [NROW_W-1:0] RST_NUM_ROWS = 8'd48;
  localparam logic [PIX_W-1:0]  RST_FG       = 32'h00FF_FFFF;
  localparam logic [PIX_W-1:0]  RST_BG       = 32'h0000_0000;
  localparam logic              RST_FORMAT   = FMT_BGRA;

  typedef enum logic [1:0] {
    ACT_DRAW   = 2'd0,
    ACT_SCROLL = 2'd1,
    ACT_REPORT = 2'd2
  } action_e;

  typedef enum logic [ADDR_W-1:0] {
    REG_ENABLE   = 3'd0,
    REG_NUM_COLS = 3'd1,
    REG_NUM_ROWS = 3'd2,
    REG_FG_COLOR = 3'd3,
    REG_BG_COLOR = 3'd4,
    REG_PIX_FMT  = 3'd5
  } reg_index_e;

  typedef struct packed {
    logic              enable;
    logic [NCOL_W-1:0] num_cols;
    logic [NROW_W-1:0] num_rows;
    logic [PIX_W-1:0]  fore_argb;
    logic [PIX_W-1:0]  back_argb;
    logic              pix_order;
  } cfg_t;

  typedef struct packed {
    logic              req_type;
    logic [CODE_W-1:0] char_code;
    logic [COL_W-1:0]  new_col;
    logic [ROW_W-1:0]  new_row;
  } req_t;

  typedef struct packed {
    logic              draw_en;
    logic              scroll_en;
    logic [COL_W-1:0]  cell_col;
    logic [ROW_W-1:0]  cell_row;
    logic [CODE_W-1:0] glyph_code;
    logic [PIX_W-1:0]  fg_pixel;
    logic [PIX_W-1:0]  bg_pixel;
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
  } step_t;

  // swap red and blue bytes for rgba
  function automatic logic [PIX_W-1:0] to_pixel(input logic [PIX_W-1:0] argb,
                                                input logic fmt);
    logic [PIX_W-1:0] res;
    res = argb;
    if (fmt == FMT_RGBA) begin
      res = {argb[31:24], argb[7:0], argb[15:8], argb[23:16]};
    end
    return res;
  endfunction

  // column count clamped to 1..MAX_COLS
  function automatic logic [NCOL_W-1:0] eff_cols(input logic [NCOL_W-1:0] n);
    logic [NCOL_W-1:0] res;
    res = n;
    if (n == '0) begin
      res = NCOL_W'(1);
    end else if (n > NCOL_W'(MAX_COLS)) begin
      res = NCOL_W'(MAX_COLS);
    end
    return res;
  endfunction

  // row count clamped to 1..MAX_ROWS
  function automatic logic [NROW_W-1:0] eff_rows(input logic [NROW_W-1:0] n);
    logic [NROW_W-1:0] res;
    res = n;
    if (n == '0) begin
      res = NROW_W'(1);
    end else if (n > NROW_W'(MAX_ROWS)) begin
      res = NROW_W'(MAX_ROWS);
    end
    return res;
  endfunction

endpackage

FILE: sv/text_console_cursor_engine.sv
// text console cursor engine: top level with config, input register, cursor
//
// Input stream s_axis carries one request per beat: tuser is the request kind
// (put character or set cursor), tdata holds the character and the new cursor.
// Output stream m_axis carries one to three beats per request, always in the
// order cell draw, scroll, cursor report; tlast marks the report, tuser holds
// the action code. The cfg channel writes one register per beat and is always
// ready; the user must write it only while the block is idle, and the block
// itself does not enforce this. An accepted request is held in the input
// register, its cursor update is worked out from that register and the
// result is loaded into the result register, from which its beats are shown.
// Throughput: one request per cycle while each yields a single report beat
// and the receiver is ready; a request with a draw or scroll holds the result
// register until its extra beats are sent, the output port being the limit.
// Reset clears the cursor to row 0, column 0, loads the register defaults
// and empties both stage registers. When the receiver stalls, the result
// register holds its beats and the input register takes one more request.
module text_console_cursor_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata from bit 0: char_code, new_col, new_row, zero pad
  input  logic [tcce_pkg::IN_DW-1:0]    s_axis_tdata,
  // tuser: req_type
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata from bit 0: cell_col, cell_row, glyph_code, fg_pixel, bg_pixel,
  // cursor_col, cursor_row, zero pad
  output logic [tcce_pkg::OUT_DW-1:0]   m_axis_tdata,
  // tuser: action
  output logic [1:0]                    m_axis_tuser,
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcce_pkg::ADDR_W-1:0]   cfg_addr,
  input  logic [tcce_pkg::PIX_W-1:0]    cfg_data
);
  import tcce_pkg::*;

  `include "text_console_cursor_engine_defines.svh"

  cfg_t             cfg;
  req_t             req;
  logic             in_valid;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  step_t            step;
  logic             load_ready;
  logic             advance;
  logic             s_fire;

  assign cfg_ready     = 1'b1;
  assign advance       = in_valid && load_ready;
  assign s_axis_tready = !in_valid || load_ready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable    <= RST_ENABLE;
      cfg.num_cols  <= RST_NUM_COLS;
      cfg.num_rows  <= RST_NUM_ROWS;
      cfg.fore_argb <= RST_FG;
      cfg.back_argb <= RST_BG;
      cfg.pix_order <= RST_FORMAT;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_e'(cfg_addr))
        REG_ENABLE:   cfg.enable    <= cfg_data[0];
        REG_NUM_COLS: cfg.num_cols  <= cfg_data[NCOL_W-1:0];
        REG_NUM_ROWS: cfg.num_rows  <= cfg_data[NROW_W-1:0];
        REG_FG_COLOR: cfg.fore_argb <= cfg_data;
        REG_BG_COLOR: cfg.back_argb <= cfg_data;
        REG_PIX_FMT:  cfg.pix_order <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // input register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (s_fire) begin
      req.req_type  <= s_axis_tuser;
      req.char_code <= s_axis_tdata[7:0];
      req.new_col   <= s_axis_tdata[15:8];
      req.new_row   <= s_axis_tdata[22:16];
    end
  end

  // cursor position
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
    end else if (advance) begin
      cur_col <= step.cur_col;
      cur_row <= step.cur_row;
    end
  end

  tcce_cursor u_cursor (
    .cfg     (cfg),
    .req     (req),
    .cur_col (cur_col),
    .cur_row (cur_row),
    .step    (step)
  );

  tcce_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .load_valid    (in_valid),
    .load_ready    (load_ready),
    .step          (step),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  `TCCE_ASSERT_NOW(a_row_on_screen, clk, rst,
    (advance && req.req_type == REQ_PUT && cfg.enable),
    ({1'b0, step.cur_row} < eff_rows(cfg.num_rows)), "cursor row left the screen")
  `TCCE_ASSERT_NOW(a_scroll_pins_row, clk, rst, step.scroll_en,
    ({1'b0, step.cur_row} == eff_rows(cfg.num_rows) - NROW_W'(1)),
    "scroll without pinning to the last row")
  `TCCE_ASSERT_NEXT(a_held_request, clk, rst, (in_valid && !advance),
    (in_valid && $stable(req)), "stalled request lost or changed")

endmodule

FILE: sv/tcce_cursor.sv
// cursor update: cell write, scroll and new cursor for one request
module tcce_cursor (
  input  tcce_pkg::cfg_t                    cfg,
  input  tcce_pkg::req_t                    req,
  input  logic [tcce_pkg::COL_W-1:0]        cur_col,
  input  logic [tcce_pkg::ROW_W-1:0]        cur_row,
  output tcce_pkg::step_t                   step
);
  import tcce_pkg::*;

  logic [NCOL_W-1:0] cols;
  logic [NROW_W-1:0] rows;
  logic [NCOL_W-1:0] col;
  logic [NROW_W-1:0] row;
  logic [NCOL_W-1:0] tab_mask;

  assign cols     = eff_cols(cfg.num_cols);
  assign rows     = eff_rows(cfg.num_rows);
  assign tab_mask = ~NCOL_W'(TAB_STOP - 1);

  always_comb begin
    step            = '0;
    step.fg_pixel   = to_pixel(cfg.fore_argb, cfg.pix_order);
    step.bg_pixel   = to_pixel(cfg.back_argb, cfg.pix_order);
    step.cur_col    = cur_col;
    step.cur_row    = cur_row;
    col             = {1'b0, cur_col};
    row             = {1'b0, cur_row};

    if (req.req_type == REQ_SET) begin
      // direct placement, stored unclamped
      step.cur_col = req.new_col;
      step.cur_row = req.new_row;
    end else if (cfg.enable) begin
      // control codes and printable characters
      case (req.char_code)
        CH_LF: begin
          col = '0;
          row = row + NROW_W'(1);
        end
        CH_CR: begin
          col = '0;
        end
        CH_TAB: begin
          col = (col & tab_mask) + NCOL_W'(TAB_STOP);
        end
        CH_BS: begin
          if (col != '0) begin
            col             = col - NCOL_W'(1);
            step.draw_en    = 1'b1;
            step.cell_col   = col[COL_W-1:0];
            step.cell_row   = row[ROW_W-1:0];
            step.glyph_code = CH_SPACE;
          end
        end
        default: begin
          if (req.char_code inside {[CH_SPACE:CH_DEL]}) begin
            step.draw_en    = 1'b1;
            step.cell_col   = col[COL_W-1:0];
            step.cell_row   = row[ROW_W-1:0];
            step.glyph_code = req.char_code;
            col             = col + NCOL_W'(1);
          end
        end
      endcase

      // column wrap
      if (col >= cols) begin
        col = '0;
        row = row + NROW_W'(1);
      end

      // row overflow scrolls once and pins to the last row
      if (row >= rows) begin
        step.scroll_en = 1'b1;
        row            = rows - NROW_W'(1);
      end

      step.cur_col = col[COL_W-1:0];
      step.cur_row = row[ROW_W-1:0];
    end
  end

endmodule

FILE: sv/tcce_emit.sv
// result register: holds one item's beats and sends them in order
module tcce_emit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load_valid,
  output logic                        load_ready,
  input  tcce_pkg::step_t             step,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tdata from bit 0: cell_col, cell_row, glyph_code, fg_pixel, bg_pixel,
  // cursor_col, cursor_row, zero pad
  output logic [tcce_pkg::OUT_DW-1:0] m_axis_tdata,
  // tuser: action
  output logic [1:0]                  m_axis_tuser,
  output logic                        m_axis_tlast
);
  import tcce_pkg::*;

  `include "text_console_cursor_engine_defines.svh"

  logic   draw_p;
  logic   scroll_p;
  logic   report_p;
  step_t  held;
  logic   fire;
  logic   load;

  assign fire       = m_axis_tvalid && m_axis_tready;
  assign load_ready = !report_p || (m_axis_tready && !draw_p && !scroll_p);
  assign load       = load_valid && load_ready;

  // pending beat flags
  always_ff @(posedge clk) begin
    if (rst) begin
      draw_p   <= 1'b0;
      scroll_p <= 1'b0;
      report_p <= 1'b0;
    end else if (load) begin
      draw_p   <= step.draw_en;
      scroll_p <= step.scroll_en;
      report_p <= 1'b1;
    end else if (fire) begin
      if (draw_p) begin
        draw_p <= 1'b0;
      end else if (scroll_p) begin
        scroll_p <= 1'b0;
      end else begin
        report_p <= 1'b0;
      end
    end
  end

  // payload of the held item
  always_ff @(posedge clk) begin
    if (load) begin
      held <= step;
    end
  end

  // beat selection: draw, then scroll, then report
  always_comb begin
    logic [COL_W-1:0]  o_cell_col;
    logic [ROW_W-1:0]  o_cell_row;
    logic [CODE_W-1:0] o_glyph;
    logic [PIX_W-1:0]  o_fg;
    logic [PIX_W-1:0]  o_bg;
    logic [COL_W-1:0]  o_cur_col;
    logic [ROW_W-1:0]  o_cur_row;
    action_e           act;

    o_cell_col   = '0;
    o_cell_row   = '0;
    o_glyph      = '0;
    o_fg         = '0;
    o_bg         = '0;
    o_cur_col    = '0;
    o_cur_row    = '0;
    act          = ACT_REPORT;
    m_axis_tlast = 1'b0;

    if (draw_p) begin
      act        = ACT_DRAW;
      o_cell_col = held.cell_col;
      o_cell_row = held.cell_row;
      o_glyph    = held.glyph_code;
      o_fg       = held.fg_pixel;
      o_bg       = held.bg_pixel;
    end else if (scroll_p) begin
      act  = ACT_SCROLL;
      o_bg = held.bg_pixel;
    end else begin
      o_cur_col    = held.cur_col;
      o_cur_row    = held.cur_row;
      m_axis_tlast = 1'b1;
    end

    m_axis_tuser = act;
    m_axis_tdata = {2'b00, o_cur_row, o_cur_col, o_bg, o_fg, o_glyph,
                    o_cell_row, o_cell_col};
  end

  assign m_axis_tvalid = report_p;

  `TCCE_ASSERT_NOW(a_report_pending, clk, rst, (draw_p || scroll_p), report_p,
    "draw or scroll pending without a report")
  `TCCE_ASSERT_NEXT(a_burst_continues, clk, rst,
    (fire && !m_axis_tlast), m_axis_tvalid, "burst broken before its last beat")
  `TCCE_ASSERT_NEXT(a_load_holds, clk, rst, load, report_p,
    "loaded item has no report pending")

endmodule

FILE: tb/tb.sv
// testbench for the text console cursor engine: cursor predictor, stream driving, checks
module tb;
  import tcce_pkg::*;

  localparam int STALL_LIMIT = 1000;

  // expected output beat, one per draw, scroll or cursor report
  typedef struct {
    action_e           act;
    logic [COL_W-1:0]  cell_col;
    logic [ROW_W-1:0]  cell_row;
    logic [CODE_W-1:0] glyph;
    logic [PIX_W-1:0]  fg_pix;
    logic [PIX_W-1:0]  bg_pix;
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic              is_last;
  } console_beat_t;

  // cursor tracker: own copy of registers and cursor, queue of pending beats
  class cursor_scoreboard;
    logic              en;
    logic [NCOL_W-1:0] ncols;
    logic [NROW_W-1:0] nrows;
    logic [PIX_W-1:0]  fg;
    logic [PIX_W-1:0]  bg;
    logic              fmt;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    console_beat_t     pending_beats[$];
    int                errors;

    function new();
      en         = RST_ENABLE;
      ncols      = RST_NUM_COLS;
      nrows      = RST_NUM_ROWS;
      fg         = RST_FG;
      bg         = RST_BG;
      fmt        = RST_FORMAT;
      cursor_col = '0;
      cursor_row = '0;
      errors     = 0;
    endfunction

    function void write_reg(reg_index_e idx, logic [PIX_W-1:0] val);
      case (idx)
        REG_ENABLE:   en = val[0];
        REG_NUM_COLS: ncols = val[NCOL_W-1:0];
        REG_NUM_ROWS: nrows = val[NROW_W-1:0];
        REG_FG_COLOR: fg = val;
        REG_BG_COLOR: bg = val;
        REG_PIX_FMT:  fmt = val[0];
        default: ;
      endcase
    endfunction

    // argb to output pixel, red and blue exchanged for rgba
    function logic [PIX_W-1:0] pixel_of(logic [PIX_W-1:0] argb);
      if (fmt == FMT_RGBA) begin
        return {argb[31:24], argb[7:0], argb[15:8], argb[23:16]};
      end
      return argb;
    endfunction

    function void push(action_e act, int ccol, int crow, int glyph,
                       logic [PIX_W-1:0] fgp, logic [PIX_W-1:0] bgp,
                       int kcol, int krow, logic is_last);
      console_beat_t b;
      b.act      = act;
      b.cell_col = ccol[COL_W-1:0];
      b.cell_row = crow[ROW_W-1:0];
      b.glyph    = glyph[CODE_W-1:0];
      b.fg_pix   = fgp;
      b.bg_pix   = bgp;
      b.cur_col  = kcol[COL_W-1:0];
      b.cur_row  = krow[ROW_W-1:0];
      b.is_last  = is_last;
      pending_beats.push_back(b);
    endfunction

    // accepted request: move the cursor and queue the beats it causes
    function void note_request(logic kind, logic [CODE_W-1:0] code,
                               logic [COL_W-1:0] ncol, logic [ROW_W-1:0] nrow);
      int cols;
      int rows;
      int col;
      int row;
      logic [PIX_W-1:0] fgp;
      logic [PIX_W-1:0] bgp;
      cols = (ncols == 0) ? 1 : ((ncols > MAX_COLS) ? MAX_COLS : int'(ncols));
      rows = (nrows == 0) ? 1 : ((nrows > MAX_ROWS) ? MAX_ROWS : int'(nrows));
      fgp  = pixel_of(fg);
      bgp  = pixel_of(bg);
      if (kind == REQ_SET) begin
        cursor_col = ncol;
        cursor_row = nrow;
      end else if (en) begin
        col = cursor_col;
        row = cursor_row;
        if (code == CH_LF) begin
          col = 0;
          row++;
        end else if (code == CH_CR) begin
          col = 0;
        end else if (code == CH_TAB) begin
          col = col - (col % TAB_STOP) + TAB_STOP;
        end else if (code == CH_BS) begin
          // blank the cell left of the cursor, nothing at column 0
          if (col > 0) begin
            col--;
            push(ACT_DRAW, col, row, CH_SPACE, fgp, bgp, 0, 0, 1'b0);
          end
        end else if (code >= CH_SPACE && code <= CH_DEL) begin
          push(ACT_DRAW, col, row, code, fgp, bgp, 0, 0, 1'b0);
          col++;
        end
        // wrap, then at most one scroll pinning to the bottom row
        if (col >= cols) begin
          col = 0;
          row++;
        end
        if (row >= rows) begin
          push(ACT_SCROLL, 0, 0, 0, '0, bgp, 0, 0, 1'b0);
          row = rows - 1;
        end
        cursor_col = col[COL_W-1:0];
        cursor_row = row[ROW_W-1:0];
      end
      push(ACT_REPORT, 0, 0, 0, '0, '0, cursor_col, cursor_row, 1'b1);
    endfunction

    function void fault(string msg);
      errors++;
      if (errors <= 10) begin
        $display("[%0t] %s", $realtime, msg);
      end
    endfunction

    function void compare(string name, logic [PIX_W-1:0] got, logic [PIX_W-1:0] want);
      if (got !== want) begin
        fault($sformatf("%s mismatch: expected %h, got %h", name, want, got));
      end
    endfunction

    // accepted output beat against the oldest pending one
    function void check_beat(logic [1:0] act, logic [OUT_DW-1:0] data, logic tl);
      console_beat_t b;
      if (pending_beats.size() == 0) begin
        fault($sformatf("unexpected beat: action %0d data %h", act, data));
        return;
      end
      b = pending_beats.pop_front();
      compare("action", act, b.act);
      compare("cell_col", data[7:0], b.cell_col);
      compare("cell_row", data[14:8], b.cell_row);
      compare("glyph_code", data[22:15], b.glyph);
      compare("fg_pixel", data[54:23], b.fg_pix);
      compare("bg_pixel", data[86:55], b.bg_pix);
      compare("cursor_col", data[94:87], b.cur_col);
      compare("cursor_row", data[101:95], b.cur_row);
      compare("pad", data[103:102], '0);
      compare("tlast", tl, b.is_last);
    endfunction

    function int pending();
      return pending_beats.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IN_DW-1:0]    s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_DW-1:0]   m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [ADDR_W-1:0]   cfg_addr;
  logic [PIX_W-1:0]    cfg_data;

  cursor_scoreboard sb;
  logic calm = 1'b1;
  int   stall_left = 0;
  int   quiet_cycles = 0;

  text_console_cursor_engine dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle length: mostly short, a few long
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 80) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 25);
  endfunction

  // receiver backpressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      m_axis_tready <= 1'b0;
      stall_left <= gap_len() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // output beat monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_beat(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // one request beat, with a random gap ahead of it
  task automatic send_req(logic kind, logic [CODE_W-1:0] code,
                          logic [COL_W-1:0] ncol, logic [ROW_W-1:0] nrow);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 30) begin
      gap = gap_len();
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {1'b0, nrow, ncol, code};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(kind, code, ncol, nrow);
    @(negedge clk);
  endtask

  task automatic put_char(logic [CODE_W-1:0] code);
    send_req(REQ_PUT, code, COL_W'($urandom()), ROW_W'($urandom()));
  endtask

  task automatic set_cursor(logic [COL_W-1:0] ncol, logic [ROW_W-1:0] nrow);
    send_req(REQ_SET, CODE_W'($urandom()), ncol, nrow);
  endtask

  // one register write beat
  task automatic write_reg(reg_index_e idx, logic [PIX_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic configure(logic en, logic [NCOL_W-1:0] ncols, logic [NROW_W-1:0] nrows,
                           logic [PIX_W-1:0] fg, logic [PIX_W-1:0] bg, logic fmt);
    write_reg(REG_NUM_COLS, PIX_W'(ncols));
    write_reg(REG_NUM_ROWS, PIX_W'(nrows));
    write_reg(REG_FG_COLOR, fg);
    write_reg(REG_BG_COLOR, bg);
    write_reg(REG_PIX_FMT, PIX_W'(fmt));
    write_reg(REG_ENABLE, PIX_W'(en));
    cfg_valid <= 1'b0;
  endtask

  // wait until every queued beat has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // random request: mostly text and control codes, some cursor moves and noise
  task automatic random_req();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      if ($urandom_range(0, 1) == 1) begin
        set_cursor(COL_W'($urandom()), ROW_W'($urandom()));
      end else begin
        set_cursor(COL_W'($urandom_range(0, 11)), ROW_W'($urandom_range(0, 5)));
      end
    end else if (r < 55) begin
      put_char(CODE_W'($urandom_range(32'h20, 32'h7F)));
    end else if (r < 80) begin
      case ($urandom_range(0, 3))
        0: put_char(CH_LF);
        1: put_char(CH_CR);
        2: put_char(CH_TAB);
        default: put_char(CH_BS);
      endcase
    end else begin
      put_char(CODE_W'($urandom()));
    end
  endtask

  task automatic random_phase(logic en, logic [NCOL_W-1:0] ncols,
                              logic [NROW_W-1:0] nrows, logic quiet, int n);
    calm = quiet;
    configure(en, ncols, nrows, $urandom(), $urandom(), 1'($urandom()));
    repeat (n) random_req();
    drain();
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_PUT;
    cfg_valid     = 1'b0;
    cfg_addr      = REG_ENABLE;
    cfg_data      = '0;
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // console disabled after reset: puts only report, set still applies
    put_char(8'h41);
    put_char(CH_LF);
    set_cursor(8'd5, 7'd2);
    put_char(8'h42);
    drain();

    // directed: small 8x4 screen, rgba swap
    configure(1'b1, 9'd8, 8'd4, 32'h1122_3344, 32'hAABB_CCDD, FMT_RGBA);
    set_cursor(8'd0, 7'd0);
    put_char(8'h41);
    put_char(CH_SPACE);
    put_char(CH_DEL);
    put_char(CH_TAB);
    put_char(CH_BS);
    put_char(CH_CR);
    put_char(CH_BS);       // at column 0: no draw
    put_char(8'h80);
    put_char(8'hFF);
    put_char(8'h00);
    put_char(8'h1B);
    put_char(CH_LF);
    set_cursor(8'd7, 7'd3);
    put_char(8'h5A);       // draw, wrap and scroll
    set_cursor(8'd255, 7'd127);
    put_char(8'h78);       // off-screen draw, then pulled back
    set_cursor(8'd6, 7'd0);
    put_char(CH_TAB);      // tab past the last column
    set_cursor(8'd0, 7'd3);
    put_char(CH_LF);
    set_cursor(8'd255, 7'd127);
    put_char(CH_BS);
    set_cursor(8'd252, 7'd127);
    put_char(CH_TAB);
    drain();

    // random phases across screen sizes, extremes first
    random_phase(1'b1, 9'd256, 8'd128, 1'b1, 25);
    random_phase(1'b1, 9'd0, 8'd0, 1'b0, 20);
    random_phase(1'b1, 9'd511, 8'd255, 1'b0, 20);
    random_phase(1'b1, 9'd1, 8'd1, 1'b0, 15);
    random_phase(1'b0, 9'd20, 8'd5, 1'b0, 15);
    repeat (4) begin
      random_phase(1'b1, NCOL_W'($urandom_range(1, 20)), NROW_W'($urandom_range(1, 6)),
                   1'($urandom_range(0, 3) == 0), 15);
    end

    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/tcce_pkg.sv
sv/tcce_cursor.sv
sv/tcce_emit.sv
sv/text_console_cursor_engine.sv
tb/tb.sv
